@@ rtl/isfp_pkg.sv @@
package isfp_pkg;

    localparam int FRAME_BYTES = 11;

    localparam logic [7:0] SYNC_BYTE  = 8'h55;
    localparam logic [7:0] TYPE_ACCEL = 8'h51;
    localparam logic [7:0] TYPE_MAG   = 8'h54;

    localparam logic [1:0] KIND_ACCEL = 2'd0;
    localparam logic [1:0] KIND_GYRO  = 2'd1;

    localparam logic [1:0] CFG_MAX_ERRORS  = 2'd0;
    localparam logic [1:0] CFG_ACCEL_LIMIT = 2'd1;
    localparam logic [1:0] CFG_GYRO_LIMIT  = 2'd2;

    localparam logic [1:0] EV_FRAME   = 2'd0;
    localparam logic [1:0] EV_SAMPLE  = 2'd1;
    localparam logic [1:0] EV_DROPPED = 2'd2;
    localparam logic [1:0] EV_RESET   = 2'd3;

    localparam logic [7:0]  MAX_ERRORS_RESET  = 8'd10;
    localparam logic [31:0] ACCEL_LIMIT_RESET = 32'd1677721600;
    localparam logic [31:0] GYRO_LIMIT_RESET  = 32'd1073741824;

    typedef logic signed [15:0] t_word;

    typedef struct packed {
        logic            is_reset;
        logic            is_pair;
        logic [1:0]      kind;
        t_word [3:0]     words;
        t_word [2:0]     acc;
        t_word [2:0]     rate;
    } t_front_rec;

    typedef struct packed {
        logic [1:0]      event_res;
        logic [1:0]      kind;
        t_word [3:0]     words;
        t_word [2:0]     acc;
        t_word [2:0]     rate;
    } t_result;

    typedef struct packed {
        logic [31:0] accel;
        logic [31:0] gyro;
    } t_limits;

endpackage

@@ rtl/imu_serial_frame_parser.sv @@
// IMU serial frame parser.
//
// Bytes from a serial receiver enter on the input queue interface: a byte is
// transferred at a rising edge with push high and full low. The parser looks
// for 11-byte frames (0x55, a type from 0x51 to 0x54, eight data bytes and an
// 8-bit sum). Each valid frame yields one result; an accel frame followed by
// a gyro frame (either order) makes a pair whose squared norms are checked
// against the limit registers. A run of checksum failures beyond max_errors
// restarts the parser and yields one error result.
// Results leave on the output queue interface: the oldest result is shown
// while empty is low and is transferred at an edge with pop high.
// Throughput is one byte per cycle while full is low. A result for the byte
// that completes its frame passes through the front queue and then the
// squaring stage ahead of the result queue.
// When the receiver stalls, the result queue fills, then the front queue,
// and full rises; nothing is lost. Configuration writes are always ready and
// must happen while no frame is in flight.
// Reset (synchronous, active low) empties the window, both queues and the
// held samples and loads the limit registers with their defaults.
module imu_serial_frame_parser
    import isfp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4,
    parameter int OUT_DEPTH   = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_rx_byte,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         o_event_res,
    output logic [1:0]         o_frame_kind,
    output logic signed [15:0] o_word_x,
    output logic signed [15:0] o_word_y,
    output logic signed [15:0] o_word_z,
    output logic signed [15:0] o_word_w,
    output logic signed [15:0] o_acc_x,
    output logic signed [15:0] o_acc_y,
    output logic signed [15:0] o_acc_z,
    output logic signed [15:0] o_rate_x,
    output logic signed [15:0] o_rate_y,
    output logic signed [15:0] o_rate_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    // Configuration registers. A write to an unused index is dropped.
    logic [7:0] r_max_errors;
    t_limits    r_limits;
    logic       cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_errors   <= MAX_ERRORS_RESET;
            r_limits.accel <= ACCEL_LIMIT_RESET;
            r_limits.gyro  <= GYRO_LIMIT_RESET;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_MAX_ERRORS:  r_max_errors   <= i_cfg_data[7:0];
                CFG_ACCEL_LIMIT: r_limits.accel <= i_cfg_data;
                CFG_GYRO_LIMIT:  r_limits.gyro  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front: sliding window, header and checksum check, pairing of samples.
    logic       emit;
    t_front_rec front_rec;
    logic       q_full, q_empty, q_rd;
    t_front_rec q_data;

    isfp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_rx_byte    (i_rx_byte),
        .i_q_full     (q_full),
        .i_max_errors (r_max_errors),
        .o_emit       (emit),
        .o_rec        (front_rec)
    );

    assign full = q_full;

    // Queue between the front and the range check.
    isfp_fifo #(
        .WIDTH ($bits(t_front_rec)),
        .DEPTH (QUEUE_DEPTH)
    ) u_front_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (emit),
        .i_wr_data (front_rec),
        .i_rd      (q_rd),
        .o_rd_data (q_data),
        .o_empty   (q_empty),
        .o_full    (q_full)
    );

    // Back: squared norms and limit compare, feeding the result queue.
    logic    out_wr, out_full;
    t_result out_data, res;

    isfp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_data   (q_data),
        .i_limits   (r_limits),
        .i_out_full (out_full),
        .o_q_rd     (q_rd),
        .o_out_wr   (out_wr),
        .o_out_data (out_data)
    );

    isfp_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_result_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (out_wr),
        .i_wr_data (out_data),
        .i_rd      (pop),
        .o_rd_data (res),
        .o_empty   (empty),
        .o_full    (out_full)
    );

    assign o_event_res  = res.event_res;
    assign o_frame_kind = res.kind;
    assign o_word_x     = res.words[0];
    assign o_word_y     = res.words[1];
    assign o_word_z     = res.words[2];
    assign o_word_w     = res.words[3];
    assign o_acc_x      = res.acc[0];
    assign o_acc_y      = res.acc[1];
    assign o_acc_z      = res.acc[2];
    assign o_rate_x     = res.rate[0];
    assign o_rate_y     = res.rate[1];
    assign o_rate_z     = res.rate[2];

endmodule

@@ rtl/isfp_fifo.sv @@
module isfp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             wr_ok, rd_ok;

    assign o_empty   = (r_cnt == '0);
    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_rd_data = r_mem[r_rp];
    assign wr_ok     = i_wr && !o_full;
    assign rd_ok     = i_rd && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr_ok) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (rd_ok) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (wr_ok && !rd_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_ok && !wr_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

endmodule

@@ rtl/isfp_front.sv @@
module isfp_front
    import isfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_rx_byte,
    input  logic       i_q_full,
    input  logic [7:0] i_max_errors,
    output logic       o_emit,
    output t_front_rec o_rec
);

    logic [7:0] r_win [FRAME_BYTES];
    logic [7:0] n_win [FRAME_BYTES];
    logic [7:0] s_win [FRAME_BYTES];
    logic [3:0] r_fill, n_fill, s_fill;
    logic [7:0] r_fail, n_fail;
    logic       r_have_acc, n_have_acc;
    logic       r_have_rate, n_have_rate;
    t_word      r_held_acc  [3];
    t_word      n_held_acc  [3];
    t_word      r_held_rate [3];
    t_word      n_held_rate [3];

    logic       accept;
    logic       header_ok;
    logic [7:0] sum;
    logic [8:0] fail_next;
    t_word      words [4];
    logic [1:0] kind;

    assign accept = i_push && !i_q_full;

    // Window after the new byte goes in: fill up first, then slide.
    always_comb begin
        s_win  = r_win;
        s_fill = r_fill;
        if (r_fill < 4'(FRAME_BYTES)) begin
            s_win[r_fill] = i_rx_byte;
            s_fill        = r_fill + 1'b1;
        end else begin
            for (int i = 0; i < FRAME_BYTES - 1; i++) begin
                s_win[i] = r_win[i + 1];
            end
            s_win[FRAME_BYTES - 1] = i_rx_byte;
        end
    end

    assign header_ok = (s_fill == 4'(FRAME_BYTES)) && (s_win[0] == SYNC_BYTE)
                    && (s_win[1] >= TYPE_ACCEL) && (s_win[1] <= TYPE_MAG);

    assign sum = ((s_win[0] + s_win[1]) + (s_win[2] + s_win[3]))
               + ((s_win[4] + s_win[5]) + (s_win[6] + s_win[7]))
               + (s_win[8] + s_win[9]);

    assign fail_next = {1'b0, r_fail} + 9'd1;
    assign kind      = 2'(s_win[1] - TYPE_ACCEL);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            words[i] = {s_win[3 + 2 * i], s_win[2 + 2 * i]};
        end
    end

    always_comb begin
        n_win       = r_win;
        n_fill      = r_fill;
        n_fail      = r_fail;
        n_have_acc  = r_have_acc;
        n_have_rate = r_have_rate;
        n_held_acc  = r_held_acc;
        n_held_rate = r_held_rate;
        o_emit      = 1'b0;
        o_rec       = '0;
        if (accept) begin
            n_win  = s_win;
            n_fill = s_fill;
            if (header_ok) begin
                if (sum != s_win[FRAME_BYTES - 1]) begin
                    if (fail_next > {1'b0, i_max_errors}) begin
                        // Too many checksum failures in a row: start over.
                        for (int i = 0; i < FRAME_BYTES; i++) begin
                            n_win[i] = '0;
                        end
                        n_fill         = '0;
                        n_fail         = '0;
                        n_have_acc     = 1'b0;
                        n_have_rate    = 1'b0;
                        o_emit         = 1'b1;
                        o_rec.is_reset = 1'b1;
                    end else begin
                        n_fail = fail_next[7:0];
                    end
                end else begin
                    for (int i = 0; i < FRAME_BYTES; i++) begin
                        n_win[i] = '0;
                    end
                    n_fill = '0;
                    n_fail = '0;
                    if (kind == KIND_ACCEL) begin
                        for (int i = 0; i < 3; i++) begin
                            n_held_acc[i] = words[i];
                        end
                        n_have_acc = 1'b1;
                    end else if (kind == KIND_GYRO) begin
                        for (int i = 0; i < 3; i++) begin
                            n_held_rate[i] = words[i];
                        end
                        n_have_rate = 1'b1;
                    end
                    o_emit     = 1'b1;
                    o_rec.kind = kind;
                    for (int i = 0; i < 4; i++) begin
                        o_rec.words[i] = words[i];
                    end
                    if (n_have_acc && n_have_rate) begin
                        o_rec.is_pair = 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            o_rec.acc[i]  = n_held_acc[i];
                            o_rec.rate[i] = n_held_rate[i];
                        end
                        n_have_acc  = 1'b0;
                        n_have_rate = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FRAME_BYTES; i++) begin
                r_win[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_held_acc[i]  <= '0;
                r_held_rate[i] <= '0;
            end
            r_fill      <= '0;
            r_fail      <= '0;
            r_have_acc  <= 1'b0;
            r_have_rate <= 1'b0;
        end else begin
            r_win       <= n_win;
            r_held_acc  <= n_held_acc;
            r_held_rate <= n_held_rate;
            r_fill      <= n_fill;
            r_fail      <= n_fail;
            r_have_acc  <= n_have_acc;
            r_have_rate <= n_have_rate;
        end
    end

    a_emit_empties_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> (r_fill == '0))
        else $error("window not emptied after a reported frame");

    a_emit_clears_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> (r_fail == '0))
        else $error("failure count not cleared after a reported frame");

    a_pair_not_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit && o_rec.is_pair |-> !o_rec.is_reset && !r_have_acc || !r_have_rate)
        else $error("pair reported without a held sample missing before");

endmodule

@@ rtl/isfp_back.sv @@
module isfp_back
    import isfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_front_rec i_q_data,
    input  t_limits    i_limits,
    input  logic       i_out_full,
    output logic       o_q_rd,
    output logic       o_out_wr,
    output t_result    o_out_data
);

    logic        r_s1_v, n_s1_v;
    t_front_rec  r_s1_rec;
    logic [31:0] r_sq_acc  [3];
    logic [31:0] r_sq_rate [3];
    logic        s1_adv;
    logic [31:0] norm_acc, norm_rate;
    logic        bad;

    assign s1_adv   = !r_s1_v || !i_out_full;
    assign o_q_rd   = s1_adv && !i_q_empty;
    assign o_out_wr = r_s1_v && !i_out_full;
    assign n_s1_v   = s1_adv ? !i_q_empty : r_s1_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= n_s1_v;
        end
    end

    // First stage: the six squares, registered.
    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_s1_rec <= i_q_data;
            for (int i = 0; i < 3; i++) begin
                r_sq_acc[i]  <= 32'($signed(i_q_data.acc[i]) * $signed(i_q_data.acc[i]));
                r_sq_rate[i] <= 32'($signed(i_q_data.rate[i]) * $signed(i_q_data.rate[i]));
            end
        end
    end

    // Second stage: the norms cannot exceed 3 * 2^30, so 32 bits hold them.
    assign norm_acc  = r_sq_acc[0] + r_sq_acc[1] + r_sq_acc[2];
    assign norm_rate = r_sq_rate[0] + r_sq_rate[1] + r_sq_rate[2];
    assign bad       = (norm_acc > i_limits.accel) || (norm_rate > i_limits.gyro);

    always_comb begin
        o_out_data.kind  = r_s1_rec.kind;
        o_out_data.words = r_s1_rec.words;
        o_out_data.acc   = r_s1_rec.acc;
        o_out_data.rate  = r_s1_rec.rate;
        priority if (r_s1_rec.is_reset) begin
            o_out_data.event_res = EV_RESET;
        end else if (r_s1_rec.is_pair) begin
            o_out_data.event_res = bad ? EV_DROPPED : EV_SAMPLE;
        end else begin
            o_out_data.event_res = EV_FRAME;
        end
    end

endmodule

@@ sim/tb_imu_serial_frame_parser.sv @@
// Testbench for the IMU serial frame parser.
//
// Bytes are fed through the push/full side from a queue of pending bytes
// that the main initial block fills phase by phase. Every byte that is
// transferred into the block is also run through a local model of the parser
// here, and any result that byte causes is appended to a queue of outstanding
// results. A monitor pops results on the empty/pop side and compares every
// field against the oldest outstanding result.
//
// Both sides wait a random number of cycles per transfer, with occasional
// stretches of back-to-back traffic. Once in the run the receiver holds off
// for a long time while the sender keeps streaming, so the block fills up
// and raises full. Register writes are only made once all traffic has
// drained and the pipeline has had time to settle.
module tb_imu_serial_frame_parser
    import isfp_pkg::*;
();

    // Frame types that the package does not name.
    localparam logic [7:0] TYPE_GYRO  = TYPE_ACCEL + 8'd1;
    localparam logic [7:0] TYPE_ANGLE = TYPE_ACCEL + 8'd2;

    // Longest time with no transfer of any kind before the run is abandoned.
    // The longest legitimate quiet spell is the receiver hold-off below.
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 8;

    // One result of the block, one member per result port.
    typedef struct {
        logic [1:0] ev;
        logic [1:0] kind;
        t_word      wx;
        t_word      wy;
        t_word      wz;
        t_word      ww;
        t_word      ax;
        t_word      ay;
        t_word      az;
        t_word      gx;
        t_word      gy;
        t_word      gz;
    } t_imu_result;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               push        = 1'b0;
    logic               full;
    logic [7:0]         i_rx_byte   = 8'h00;
    logic               empty;
    logic               pop         = 1'b0;
    logic [1:0]         o_event_res;
    logic [1:0]         o_frame_kind;
    logic signed [15:0] o_word_x;
    logic signed [15:0] o_word_y;
    logic signed [15:0] o_word_z;
    logic signed [15:0] o_word_w;
    logic signed [15:0] o_acc_x;
    logic signed [15:0] o_acc_y;
    logic signed [15:0] o_acc_z;
    logic signed [15:0] o_rate_x;
    logic signed [15:0] o_rate_y;
    logic signed [15:0] o_rate_z;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = CFG_MAX_ERRORS;
    logic [31:0]        i_cfg_data  = 32'd0;

    imu_serial_frame_parser i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_rx_byte    (i_rx_byte),
        .empty        (empty),
        .pop          (pop),
        .o_event_res  (o_event_res),
        .o_frame_kind (o_frame_kind),
        .o_word_x     (o_word_x),
        .o_word_y     (o_word_y),
        .o_word_z     (o_word_z),
        .o_word_w     (o_word_w),
        .o_acc_x      (o_acc_x),
        .o_acc_y      (o_acc_y),
        .o_acc_z      (o_acc_z),
        .o_rate_x     (o_rate_x),
        .o_rate_y     (o_rate_y),
        .o_rate_z     (o_rate_z),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Stimulus and checking state.
    logic [7:0]  tx_bytes[$];
    t_imu_result results_due[$];
    int          mismatch_count = 0;
    int          tx_wait        = 0;
    int          rx_wait        = 0;
    bit          tx_steady      = 1'b0;
    bit          rx_steady      = 1'b0;
    logic        rx_hold        = 1'b0;
    bit          hold_req       = 1'b0;

    // Local copy of the parser state, starting from its reset values.
    logic [7:0]  win[FRAME_BYTES] = '{default: 8'h00};
    int          win_fill       = 0;
    logic [7:0]  fail_run       = 8'd0;
    bit          have_acc       = 1'b0;
    bit          have_rate      = 1'b0;
    t_word       held_acc[3]    = '{default: 16'sd0};
    t_word       held_rate[3]   = '{default: 16'sd0};
    logic [7:0]  lim_errors     = MAX_ERRORS_RESET;
    logic [31:0] lim_accel      = ACCEL_LIMIT_RESET;
    logic [31:0] lim_gyro       = GYRO_LIMIT_RESET;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Every mismatch goes through here: one line each, and it is counted.
    task automatic log_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            log_mismatch($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    // Squared Euclidean norm of a raw 3-axis sample. Three squares of 16-bit
    // signed values never exceed 3 * 2^30, so no wrap is possible.
    function automatic longint norm_sq(input t_word a, input t_word b,
                                       input t_word c);
        return longint'(a) * longint'(a) + longint'(b) * longint'(b)
             + longint'(c) * longint'(c);
    endfunction

    // Model of the parser for one received byte. Pushes the result, if the
    // byte causes one, onto the outstanding queue.
    task automatic parse_byte(input logic [7:0] b);
        logic [7:0]  csum;
        logic [8:0]  next_fails;
        logic [1:0]  kind;
        t_word       w[4];
        t_imu_result r;
        int          k;

        // The window fills from the front, then slides one byte per byte.
        if (win_fill < FRAME_BYTES) begin
            win[win_fill] = b;
            win_fill++;
        end else begin
            for (k = 0; k < FRAME_BYTES - 1; k++) begin
                win[k] = win[k + 1];
            end
            win[FRAME_BYTES - 1] = b;
        end
        if (win_fill < FRAME_BYTES) begin
            return;
        end
        if (win[0] != SYNC_BYTE || win[1] < TYPE_ACCEL || win[1] > TYPE_MAG) begin
            return;
        end

        csum = 8'd0;
        for (k = 0; k < FRAME_BYTES - 1; k++) begin
            csum = csum + win[k];
        end
        r = '{ev: EV_FRAME, kind: KIND_ACCEL, default: 16'sd0};

        if (csum != win[FRAME_BYTES - 1]) begin
            // A checksum failure past the allowed run restarts the parser.
            next_fails = {1'b0, fail_run} + 9'd1;
            if (next_fails > {1'b0, lim_errors}) begin
                win       = '{default: 8'h00};
                win_fill  = 0;
                fail_run  = 8'd0;
                have_acc  = 1'b0;
                have_rate = 1'b0;
                r.ev      = EV_RESET;
                results_due.push_back(r);
            end else begin
                fail_run = next_fails[7:0];
            end
            return;
        end

        fail_run = 8'd0;
        win_fill = 0;
        kind     = 2'(win[1] - TYPE_ACCEL);
        for (k = 0; k < 4; k++) begin
            w[k] = {win[3 + 2 * k], win[2 + 2 * k]};
        end
        win = '{default: 8'h00};

        if (kind == KIND_ACCEL) begin
            for (k = 0; k < 3; k++) begin
                held_acc[k] = w[k];
            end
            have_acc = 1'b1;
        end else if (kind == KIND_GYRO) begin
            for (k = 0; k < 3; k++) begin
                held_rate[k] = w[k];
            end
            have_rate = 1'b1;
        end

        r.kind = kind;
        r.wx   = w[0];
        r.wy   = w[1];
        r.wz   = w[2];
        r.ww   = w[3];

        // An accel and a gyro sample together form a pair that is range
        // checked against both limits; the held values stay, the flags clear.
        if (have_acc && have_rate) begin
            if (norm_sq(held_acc[0], held_acc[1], held_acc[2]) > longint'(lim_accel)
                || norm_sq(held_rate[0], held_rate[1], held_rate[2])
                   > longint'(lim_gyro)) begin
                r.ev = EV_DROPPED;
            end else begin
                r.ev = EV_SAMPLE;
            end
            r.ax      = held_acc[0];
            r.ay      = held_acc[1];
            r.az      = held_acc[2];
            r.gx      = held_rate[0];
            r.gy      = held_rate[1];
            r.gz      = held_rate[2];
            have_acc  = 1'b0;
            have_rate = 1'b0;
        end
        results_due.push_back(r);
    endtask

    // Per-transfer wait. Now and then a side switches between random waits
    // and back-to-back transfers.
    function automatic int pick_gap(inout bit steady);
        if ($urandom_range(0, 39) == 0) begin
            steady = !steady;
        end
        return steady ? 0 : int'($urandom_range(0, 16));
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'($urandom);
            4, 5, 6:    return 16'($urandom_range(0, 8191)) - 16'd4096;
            7:          return 16'h7FFF;
            8:          return 16'h8000;
            default:    return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    // Four words packed as {w, z, y, x}.
    function automatic logic [63:0] rand_words();
        return {rand_word(), rand_word(), rand_word(), rand_word()};
    endfunction

    // Accel and gyro frames are favored so that pairs form often.
    function automatic logic [7:0] rand_type();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6:       return TYPE_ACCEL;
            7, 8, 9, 10, 11, 12, 13:   return TYPE_GYRO;
            14, 15, 16:                return TYPE_ANGLE;
            default:                   return TYPE_MAG;
        endcase
    endfunction

    // Builds one frame and queues its first 'keep' bytes. A corrupted frame
    // gets a checksum that is guaranteed to be wrong.
    task automatic queue_frame(input logic [7:0] ftype, input logic [63:0] words,
                               input int keep, input bit corrupt);
        logic [7:0] fb[FRAME_BYTES];
        logic [7:0] csum;
        int         k;

        fb[0] = SYNC_BYTE;
        fb[1] = ftype;
        for (k = 0; k < 8; k++) begin
            fb[2 + k] = words[8 * k +: 8];
        end
        csum = 8'd0;
        for (k = 0; k < FRAME_BYTES - 1; k++) begin
            csum = csum + fb[k];
        end
        fb[FRAME_BYTES - 1] = corrupt ? csum ^ 8'($urandom_range(1, 255)) : csum;
        for (k = 0; k < keep; k++) begin
            tx_bytes.push_back(fb[k]);
        end
    endtask

    // Sync byte followed by a valid type, repeated: once the window is full
    // every second byte lines up a header whose checksum fails.
    task automatic queue_sync_flood(input int pairs);
        repeat (pairs) begin
            tx_bytes.push_back(SYNC_BYTE);
            tx_bytes.push_back(TYPE_ACCEL + 8'($urandom_range(0, 3)));
        end
    endtask

    // Mostly well-formed frames with random content; bad_pct percent of the
    // units are broken: bad checksums, cut-off frames, noise, header floods
    // and frames with an out-of-range type.
    task automatic queue_traffic(input int n_bytes, input int bad_pct);
        int start;

        start = tx_bytes.size();
        while (tx_bytes.size() - start < n_bytes) begin
            if ($urandom_range(0, 99) < bad_pct) begin
                case ($urandom_range(0, 4))
                    0: queue_frame(rand_type(), rand_words(), FRAME_BYTES, 1'b1);
                    1: queue_frame(rand_type(), rand_words(), $urandom_range(1, 10), 1'b0);
                    2: begin
                        repeat ($urandom_range(1, 4)) begin
                            tx_bytes.push_back($urandom_range(0, 1) ? SYNC_BYTE
                                                                    : 8'($urandom));
                        end
                    end
                    3: queue_sync_flood($urandom_range(1, 15));
                    default: begin
                        queue_frame($urandom_range(0, 1) ? TYPE_ACCEL - 8'd1
                                                         : 8'($urandom),
                                    rand_words(), FRAME_BYTES, 1'b0);
                    end
                endcase
            end else begin
                queue_frame(rand_type(), rand_words(), FRAME_BYTES, 1'b0);
            end
        end
    endtask

    // Waits until every byte has been transferred and every outstanding
    // result has been popped, then gives the block time to finish bytes
    // that are still in flight without a result.
    task automatic drain(input int extra);
        while (tx_bytes.size() != 0 || push || results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MAX_ERRORS:  lim_errors = val[7:0];
            CFG_ACCEL_LIMIT: lim_accel  = val;
            CFG_GYRO_LIMIT:  lim_gyro   = val;
            default: ;
        endcase
    endtask

    // Byte sender. A new byte is offered when the line is free, either
    // because nothing was offered or because the offer was just taken.
    // During the receiver hold-off it streams without pauses.
    always @(posedge i_clk) begin : byte_driver
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                parse_byte(i_rx_byte);
            end
            if (!push || !full) begin
                if (tx_wait > 0 && !rx_hold) begin
                    tx_wait--;
                    push <= 1'b0;
                end else if (tx_bytes.size() != 0) begin
                    push      <= 1'b1;
                    i_rx_byte <= tx_bytes.pop_front();
                    tx_wait   = rx_hold ? 0 : pick_gap(tx_steady);
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Result receiver and checker. Every popped result is matched against
    // the oldest outstanding one, field by field.
    always @(posedge i_clk) begin : result_monitor
        t_imu_result want;

        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (results_due.size() == 0) begin
                    log_mismatch($sformatf("unexpected result, event %0d kind %0d",
                                           o_event_res, o_frame_kind));
                end else begin
                    want = results_due.pop_front();
                    check_field("event_res", o_event_res, want.ev);
                    check_field("frame_kind", o_frame_kind, want.kind);
                    check_field("word_x", o_word_x, want.wx);
                    check_field("word_y", o_word_y, want.wy);
                    check_field("word_z", o_word_z, want.wz);
                    check_field("word_w", o_word_w, want.ww);
                    check_field("acc_x", o_acc_x, want.ax);
                    check_field("acc_y", o_acc_y, want.ay);
                    check_field("acc_z", o_acc_z, want.az);
                    check_field("rate_x", o_rate_x, want.gx);
                    check_field("rate_y", o_rate_y, want.gy);
                    check_field("rate_z", o_rate_z, want.gz);
                end
                rx_wait = pick_gap(rx_steady);
            end
            if (rx_hold) begin
                pop <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Long receiver hold-off, timed here so that the sender keeps going and
    // the block has to back up all the way to its input.
    initial begin : receiver_hold
        forever begin
            wait (hold_req);
            hold_req = 1'b0;
            @(posedge i_clk);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    // Ends the run if no transfer of any kind happens for too long.
    initial begin : watchdog
        int quiet;

        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (push && !full) || (pop && !empty)
                || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the reset register values. The extreme
        // accel sample is held and later paired with a gyro frame; its norm
        // is above the default accel limit, so that pair is dropped.
        queue_frame(TYPE_ACCEL, {16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF},
                    FRAME_BYTES, 1'b0);
        queue_frame(TYPE_ANGLE, {16'h1234, 16'h8001, 16'h7FFE, 16'h00FF},
                    FRAME_BYTES, 1'b0);
        queue_frame(TYPE_MAG, {16'h0B00, 16'hFF00, 16'h0001, 16'hFFFE},
                    FRAME_BYTES, 1'b0);
        // Noise bytes and out-of-range types are ignored.
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'hFF);
        tx_bytes.push_back(SYNC_BYTE);
        queue_frame(TYPE_ACCEL - 8'd1, rand_words(), FRAME_BYTES, 1'b0);
        queue_frame(TYPE_MAG + 8'd1, rand_words(), FRAME_BYTES, 1'b0);
        // A bad checksum counts a failure and gives no result.
        queue_frame(TYPE_GYRO, rand_words(), FRAME_BYTES, 1'b1);
        queue_frame(TYPE_GYRO, {16'h0000, 16'h0100, 16'hFF00, 16'h0010},
                    FRAME_BYTES, 1'b0);
        // Gyro before accel, both small: the pair passes the range check.
        queue_frame(TYPE_GYRO, {16'h5555, 16'hFFF0, 16'h0020, 16'h0300},
                    FRAME_BYTES, 1'b0);
        queue_frame(TYPE_ACCEL, {16'hAAAA, 16'h0800, 16'hF800, 16'h0400},
                    FRAME_BYTES, 1'b0);
        drain(SETTLE_CYCLES);

        // No failure tolerated and limits at the largest norm that can occur.
        write_reg(CFG_MAX_ERRORS, 32'd0);
        write_reg(CFG_ACCEL_LIMIT, 32'd3221225472);
        write_reg(CFG_GYRO_LIMIT, 32'd3221225472);
        queue_traffic(150, 20);
        drain(SETTLE_CYCLES);

        // Widest failure run and zero limits: a long header flood is needed
        // to reach the restart, and only an all-zero pair passes.
        write_reg(CFG_MAX_ERRORS, 32'd255);
        write_reg(CFG_ACCEL_LIMIT, 32'd0);
        write_reg(CFG_GYRO_LIMIT, 32'd0);
        queue_sync_flood(300);
        queue_frame(TYPE_ACCEL, 64'd0, FRAME_BYTES, 1'b0);
        queue_frame(TYPE_GYRO, 64'd0, FRAME_BYTES, 1'b0);
        queue_traffic(100, 15);
        drain(SETTLE_CYCLES);

        // Random limits; the receiver stalls while valid frames stream in.
        write_reg(CFG_MAX_ERRORS, 32'd3);
        write_reg(CFG_ACCEL_LIMIT, $urandom);
        write_reg(CFG_GYRO_LIMIT, $urandom);
        hold_req = 1'b1;
        queue_traffic(200, 0);
        drain(SETTLE_CYCLES);

        // Limits near typical pair norms, so both outcomes are common.
        write_reg(CFG_MAX_ERRORS, $urandom_range(1, 12));
        write_reg(CFG_ACCEL_LIMIT, $urandom_range(32'h2000_0000, 32'h7000_0000));
        write_reg(CFG_GYRO_LIMIT, $urandom_range(32'h1000_0000, 32'h6000_0000));
        queue_traffic(200, 25);
        drain(SETTLE_CYCLES);

        // Back to the reset values with heavy breakage, so that restarts
        // after the default number of failures occur.
        write_reg(CFG_MAX_ERRORS, 32'(MAX_ERRORS_RESET));
        write_reg(CFG_ACCEL_LIMIT, ACCEL_LIMIT_RESET);
        write_reg(CFG_GYRO_LIMIT, GYRO_LIMIT_RESET);
        queue_traffic(200, 60);
        drain(2 * SETTLE_CYCLES);

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
